// ===== design/prescaled_compare_timer_assert.svh =====
// Assertion macros for the prescaled compare timer.
// Expects clk and rst_n in the scope of use; empty under SYNTHESIS.
`ifndef PRESCALED_COMPARE_TIMER_ASSERT_SVH
`define PRESCALED_COMPARE_TIMER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pct assertion failed");
`define PCT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pct assertion failed");
`define PCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pct assertion failed");
`else
`define PCT_ASSERT_ALWAYS(lbl, cond)
`define PCT_ASSERT_IMPLY(lbl, ante, cons)
`define PCT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/pct_pkg.sv =====
// Shared constants, codes and types of the prescaled compare timer.
// No dependencies.
`default_nettype none
package pct_pkg;

  localparam int unsigned PRESCALE_DIVIDER = 384;
  localparam int unsigned RESTART_DELAY    = 3;
  localparam int unsigned COUNT_BITS       = 16;
  localparam int unsigned DATA_BITS        = 16;
  localparam int unsigned CYCLE_BITS       = 16;
  localparam int unsigned ACC_BITS         = 9;
  localparam int unsigned TOTAL_BITS       = 17;

  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  localparam logic [2:0] REG_CTRL  = 3'd0;
  localparam logic [2:0] REG_COUNT = 3'd1;
  localparam logic [2:0] REG_CMP0  = 3'd2;
  localparam logic [2:0] REG_CMP1  = 3'd3;

  localparam int unsigned CTRL_ENABLE  = 0;
  localparam int unsigned CTRL_RUNNING = 1;
  localparam int unsigned CTRL_RESTART = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MASK = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic                  more;
    logic [TOTAL_BITS-1:0] total_nxt;
    logic [COUNT_BITS-1:0] count_nxt;
    logic                  hit0;
    logic                  hit1;
  } step_t;

endpackage
`default_nettype wire

// ===== design/prescaled_compare_timer.sv =====
// Prescaled compare timer: four registers, read/write/advance words, one result each.
// Uses pct_pkg, pct_step_unit and prescaled_compare_timer_assert.svh.
//
// A read, a write, an unknown op or an advance that does not run loads its
// result into the output register from ST_IDLE; a running advance goes to
// ST_TICK, where the single subtract-and-increment step unit handles one
// prescaled tick per cycle. A new word is taken only once the output register
// is free, that is when no result is held or the held one leaves in the same
// cycle, and never while the block is busy with an advance.
`default_nettype none
module prescaled_compare_timer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_op,
  input  wire logic [2:0]                        in_reg_index,
  input  wire logic [pct_pkg::DATA_BITS-1:0]     in_write_data,
  input  wire logic [pct_pkg::CYCLE_BITS-1:0]    in_cycle_count,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [pct_pkg::DATA_BITS-1:0]          out_read_data,
  output logic                                   out_irq_compare0,
  output logic                                   out_irq_compare1,
  output logic                                   out_active
);
  import pct_pkg::*;

  `include "prescaled_compare_timer_assert.svh"

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_TICK = 1'b1;

  logic [0:0]            state_r, state_nxt;
  logic                  enable_r, enable_nxt;
  logic                  running_r, running_nxt;
  logic                  waiting_r, waiting_nxt;
  logic [1:0]            left_r, left_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] cmp0_r, cmp0_nxt;
  logic [COUNT_BITS-1:0] cmp1_r, cmp1_nxt;
  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic                  hit0_r, hit0_nxt;
  logic                  hit1_r, hit1_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_BITS-1:0]  out_data_r, out_data_nxt;
  logic                  out_irq0_r, out_irq0_nxt;
  logic                  out_irq1_r, out_irq1_nxt;
  logic                  out_active_r, out_active_nxt;

  step_t                 step;
  logic                  out_free;
  logic                  in_fire;
  logic                  load;
  logic                  run_eff;
  logic [ACC_BITS-1:0]   acc_eff;
  logic [CYCLE_BITS-1:0] cyc_eff;
  logic [DATA_BITS-1:0]  rd_data;

  pct_step_unit u_step (
    .total (total_r),
    .count (count_r),
    .cmp0  (cmp0_r),
    .cmp1  (cmp1_r),
    .step  (step)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_irq_compare0 = out_irq0_r;
  assign out_irq_compare1 = out_irq1_r;
  assign out_active       = out_active_r;

  always_comb begin
    case (in_reg_index)
      REG_CTRL:  rd_data = DATA_BITS'({running_r, enable_r});
      REG_COUNT: rd_data = DATA_BITS'(count_r);
      REG_CMP0:  rd_data = DATA_BITS'(cmp0_r);
      REG_CMP1:  rd_data = DATA_BITS'(cmp1_r);
      default:   rd_data = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    enable_nxt     = enable_r;
    running_nxt    = running_r;
    waiting_nxt    = waiting_r;
    left_nxt       = left_r;
    count_nxt      = count_r;
    cmp0_nxt       = cmp0_r;
    cmp1_nxt       = cmp1_r;
    acc_nxt        = acc_r;
    total_nxt      = total_r;
    hit0_nxt       = hit0_r;
    hit1_nxt       = hit1_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_irq0_nxt   = out_irq0_r;
    out_irq1_nxt   = out_irq1_r;
    out_active_nxt = out_active_r;
    load           = 1'b0;
    run_eff        = running_r;
    acc_eff        = acc_r;
    cyc_eff        = in_cycle_count;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_READ: begin
              load         = 1'b1;
              out_data_nxt = rd_data;
              out_irq0_nxt = 1'b0;
              out_irq1_nxt = 1'b0;
            end
            OP_WRITE: begin
              load         = 1'b1;
              out_data_nxt = '0;
              out_irq0_nxt = 1'b0;
              out_irq1_nxt = 1'b0;
              case (in_reg_index)
                REG_CTRL: begin
                  if (!in_write_data[CTRL_ENABLE]) begin
                    enable_nxt  = 1'b0;
                    running_nxt = 1'b0;
                    left_nxt    = '0;
                    waiting_nxt = 1'b0;
                  end else if (in_write_data[CTRL_RESTART]) begin
                    enable_nxt  = 1'b1;
                    running_nxt = 1'b0;
                    left_nxt    = 2'(RESTART_DELAY);
                    waiting_nxt = 1'b1;
                  end else begin
                    enable_nxt  = 1'b1;
                  end
                end
                REG_CMP0: cmp0_nxt = COUNT_BITS'(in_write_data);
                REG_CMP1: cmp1_nxt = COUNT_BITS'(in_write_data);
                default: ;
              endcase
            end
            OP_ADVANCE: begin
              if (waiting_r) begin
                if (in_cycle_count < CYCLE_BITS'(left_r)) begin
                  left_nxt = left_r - in_cycle_count[1:0];
                  run_eff  = 1'b0;
                end else begin
                  cyc_eff     = in_cycle_count - CYCLE_BITS'(left_r);
                  count_nxt   = '0;
                  acc_eff     = '0;
                  left_nxt    = '0;
                  waiting_nxt = 1'b0;
                  running_nxt = 1'b1;
                  run_eff     = 1'b1;
                end
              end
              if (run_eff) begin
                total_nxt = TOTAL_BITS'(acc_eff) + TOTAL_BITS'(cyc_eff);
                hit0_nxt  = 1'b0;
                hit1_nxt  = 1'b0;
                state_nxt = ST_TICK;
              end else begin
                load         = 1'b1;
                out_data_nxt = '0;
                out_irq0_nxt = 1'b0;
                out_irq1_nxt = 1'b0;
              end
            end
            default: begin
              load         = 1'b1;
              out_data_nxt = '0;
              out_irq0_nxt = 1'b0;
              out_irq1_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_TICK: begin
        if (step.more) begin
          total_nxt = step.total_nxt;
          count_nxt = step.count_nxt;
          hit0_nxt  = hit0_r | step.hit0;
          hit1_nxt  = hit1_r | step.hit1;
        end else begin
          if (out_free) begin
            acc_nxt      = total_r[ACC_BITS-1:0];
            running_nxt  = (count_r != COUNT_MASK);
            load         = 1'b1;
            out_data_nxt = '0;
            out_irq0_nxt = hit0_r;
            out_irq1_nxt = hit1_r;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (load) begin
      out_valid_nxt  = 1'b1;
      out_active_nxt = waiting_nxt | running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      running_r   <= 1'b0;
      waiting_r   <= 1'b0;
      left_r      <= '0;
      count_r     <= '0;
      cmp0_r      <= COUNT_MASK;
      cmp1_r      <= COUNT_MASK;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      running_r   <= running_nxt;
      waiting_r   <= waiting_nxt;
      left_r      <= left_nxt;
      count_r     <= count_nxt;
      cmp0_r      <= cmp0_nxt;
      cmp1_r      <= cmp1_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r      <= total_nxt;
    hit0_r       <= hit0_nxt;
    hit1_r       <= hit1_nxt;
    out_data_r   <= out_data_nxt;
    out_irq0_r   <= out_irq0_nxt;
    out_irq1_r   <= out_irq1_nxt;
    out_active_r <= out_active_nxt;
  end

  `PCT_ASSERT_IMPLY(a_tick_running, state_r == ST_TICK, running_r && !waiting_r)
  `PCT_ASSERT_IMPLY(a_acc_range, state_r == ST_IDLE, acc_r < ACC_BITS'(PRESCALE_DIVIDER))
  `PCT_ASSERT_NEXT(a_short_word, in_fire && in_op != OP_ADVANCE, out_valid_r)
  `PCT_ASSERT_ALWAYS(a_run_needs_enable, !(running_r || waiting_r) || enable_r)

endmodule
`default_nettype wire

// ===== design/pct_step_unit.sv =====
// One prescaler step: take a divider's worth of cycles off the total and
// advance the count unless it is terminal. Uses pct_pkg.
`default_nettype none
module pct_step_unit (
  input  wire logic [pct_pkg::TOTAL_BITS-1:0] total,
  input  wire logic [pct_pkg::COUNT_BITS-1:0] count,
  input  wire logic [pct_pkg::COUNT_BITS-1:0] cmp0,
  input  wire logic [pct_pkg::COUNT_BITS-1:0] cmp1,
  output pct_pkg::step_t                      step
);
  import pct_pkg::*;

  logic [COUNT_BITS-1:0] count_inc;
  logic                  can_tick;

  always_comb begin
    count_inc      = count + COUNT_BITS'(1);
    can_tick       = (count != COUNT_MASK);
    step.more      = (total >= TOTAL_BITS'(PRESCALE_DIVIDER));
    step.total_nxt = total - TOTAL_BITS'(PRESCALE_DIVIDER);
    step.count_nxt = can_tick ? count_inc : count;
    step.hit0      = step.more && can_tick && (count_inc == cmp0);
    step.hit1      = step.more && can_tick && (count_inc == cmp1);
  end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for prescaled_compare_timer: read, write and advance words go in, and each status
// word out is checked against the timer model in this file, or its table row if fixed.
// Depends on pct_pkg and the prescaled_compare_timer RTL.
module tb_top;
  import pct_pkg::*;

  localparam logic [1:0]  OP_NONE      = 2'd3;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASE_WORDS  = 25;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned N_DIRECTED   = 25;

  typedef struct packed {
    logic [1:0]            op;
    logic [2:0]            idx;
    logic [DATA_BITS-1:0]  wdata;
    logic [CYCLE_BITS-1:0] cyc;
  } timer_word_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] rdata;
    logic                 irq0;
    logic                 irq1;
    logic                 active;
  } timer_status_t;

  typedef struct packed {
    timer_word_t   word;
    logic          fixed;
    timer_status_t want;
  } directed_row_t;

  localparam directed_row_t DIRECTED_WORDS [N_DIRECTED] = '{
    '{'{OP_READ,    REG_CTRL,  16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,    REG_COUNT, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,    REG_CMP0,  16'h0000, 16'h0000}, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,    REG_CMP1,  16'h0000, 16'h0000}, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,    3'd7,      16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_NONE,    3'd7,      16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_ADVANCE, REG_CTRL,  16'h0000, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE,   REG_CMP0,  16'h0002, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE,   REG_CMP1,  16'h00AC, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE,   3'd5,      16'hFFFF, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE,   REG_COUNT, 16'h1234, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE,   REG_CTRL,  16'h0005, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b1}},
    '{'{OP_ADVANCE, REG_CTRL,  16'h0000, 16'h0002}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b1}},
    '{'{OP_READ,    REG_CTRL,  16'h0000, 16'h0000}, 1'b1, '{16'h0001, 1'b0, 1'b0, 1'b1}},
    '{'{OP_ADVANCE, REG_CTRL,  16'h0000, 16'h0301}, 1'b0, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_ADVANCE, REG_CTRL,  16'h0000, 16'hFFFF}, 1'b0, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,    REG_COUNT, 16'h0000, 16'h0000}, 1'b0, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE,   REG_CTRL,  16'h0001, 16'h0000}, 1'b0, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_ADVANCE, REG_CTRL,  16'h0000, 16'h0000}, 1'b0, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE,   REG_CTRL,  16'hFFFA, 16'h0000}, 1'b0, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,    REG_CTRL,  16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE,   REG_CTRL,  16'hFFFF, 16'h0000}, 1'b0, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_ADVANCE, REG_CTRL,  16'h0000, 16'h0003}, 1'b0, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,    REG_CTRL,  16'h0000, 16'h0000}, 1'b0, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE,   REG_CTRL,  16'h0000, 16'h0000}, 1'b0, '{16'h0000, 1'b0, 1'b0, 1'b0}}
  };

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic [1:0]            in_op          = OP_READ;
  logic [2:0]            in_reg_index   = REG_CTRL;
  logic [DATA_BITS-1:0]  in_write_data  = '0;
  logic [CYCLE_BITS-1:0] in_cycle_count = '0;
  logic                  out_ready      = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [DATA_BITS-1:0]  out_read_data;
  logic                  out_irq_compare0;
  logic                  out_irq_compare1;
  logic                  out_active;

  prescaled_compare_timer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_reg_index     (in_reg_index),
    .in_write_data    (in_write_data),
    .in_cycle_count   (in_cycle_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_irq_compare0 (out_irq_compare0),
    .out_irq_compare1 (out_irq_compare1),
    .out_active       (out_active)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // timer model state
  logic                  t_enable;
  logic                  t_running;
  logic                  t_restart_wait;
  logic [COUNT_BITS-1:0] t_count;
  logic [COUNT_BITS-1:0] t_cmp0;
  logic [COUNT_BITS-1:0] t_cmp1;
  int unsigned           t_acc;
  int unsigned           t_restart_left;

  timer_status_t status_due[$];
  int unsigned   failures       = 0;
  int unsigned   quiet_cycles   = 0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   stall_pct      = 0;
  int unsigned   hold_left      = 0;

  function automatic timer_status_t timer_status_after(input timer_word_t w);
    timer_status_t r;
    int unsigned   cyc, total, ticks, room, steps, hi;
    logic          held;
    r    = '0;
    held = 1'b0;
    case (w.op)
      OP_READ: begin
        case (w.idx)
          REG_CTRL: begin
            r.rdata[CTRL_ENABLE]  = t_enable;
            r.rdata[CTRL_RUNNING] = t_running;
          end
          REG_COUNT: r.rdata = t_count;
          REG_CMP0:  r.rdata = t_cmp0;
          REG_CMP1:  r.rdata = t_cmp1;
          default:   r.rdata = '0;
        endcase
      end
      OP_WRITE: begin
        case (w.idx)
          REG_CTRL: begin
            if (!w.wdata[CTRL_ENABLE]) begin
              t_enable       = 1'b0;
              t_running      = 1'b0;
              t_restart_left = 0;
              t_restart_wait = 1'b0;
            end else if (w.wdata[CTRL_RESTART]) begin
              t_enable       = 1'b1;
              t_running      = 1'b0;
              t_restart_left = RESTART_DELAY & 3;
              t_restart_wait = 1'b1;
            end else begin
              t_enable = 1'b1;
            end
          end
          REG_CMP0: t_cmp0 = w.wdata;
          REG_CMP1: t_cmp1 = w.wdata;
          default: ;
        endcase
      end
      OP_ADVANCE: begin
        cyc = w.cyc;
        if (t_restart_wait) begin
          if (cyc < t_restart_left) begin
            t_restart_left -= cyc;
            held = 1'b1;
          end else begin
            cyc -= t_restart_left;
            t_count        = '0;
            t_acc          = 0;
            t_restart_left = 0;
            t_running      = 1'b1;
            t_restart_wait = 1'b0;
          end
        end
        if (!held && t_running) begin
          total = t_acc + cyc;
          ticks = total / PRESCALE_DIVIDER;
          room  = int'(COUNT_MASK) - int'(t_count);
          steps = (ticks < room) ? ticks : room;
          hi    = int'(t_count) + steps;
          r.irq0 = (int'(t_cmp0) > int'(t_count)) && (int'(t_cmp0) <= hi);
          r.irq1 = (int'(t_cmp1) > int'(t_count)) && (int'(t_cmp1) <= hi);
          t_count = hi[COUNT_BITS-1:0];
          total  -= steps * PRESCALE_DIVIDER;
          // terminal count: stop, drop leftover whole ticks
          if (t_count == COUNT_MASK) begin
            t_running = 1'b0;
            total     = total % PRESCALE_DIVIDER;
          end
          t_acc = total & 511;
        end
      end
      default: ;
    endcase
    r.active = t_restart_wait | t_running;
    return r;
  endfunction

  // mostly live traffic: restart when idle, compares placed just ahead of the count
  function automatic timer_word_t pick_word();
    timer_word_t w;
    int unsigned roll, pick;
    w.op    = OP_READ;
    w.idx   = 3'($urandom_range(7));
    w.wdata = 16'($urandom);
    w.cyc   = 16'($urandom);
    roll    = $urandom_range(99);
    if (!(t_running || t_restart_wait) && roll < 25) begin
      w.op                  = OP_WRITE;
      w.idx                 = REG_CTRL;
      w.wdata[CTRL_ENABLE]  = 1'b1;
      w.wdata[CTRL_RESTART] = 1'b1;
    end else if (roll < 30) begin
      w.op = OP_NONE;
    end else if (roll < 55) begin
      w.op = OP_READ;
    end else if (roll < 75) begin
      w.op = OP_WRITE;
      pick = $urandom_range(9);
      if (pick < 4) begin
        w.idx = REG_CTRL;
        pick  = $urandom_range(9);
        if (pick < 2) begin
          w.wdata[CTRL_ENABLE] = 1'b0;
        end else begin
          w.wdata[CTRL_ENABLE]  = 1'b1;
          w.wdata[CTRL_RESTART] = (pick < 6);
        end
      end else if (pick < 8) begin
        w.idx = pick[0] ? REG_CMP1 : REG_CMP0;
        if ($urandom_range(3) != 0) w.wdata = 16'(t_count + $urandom_range(300));
      end
    end else begin
      w.op = OP_ADVANCE;
      pick = $urandom_range(9);
      if (pick < 3) w.cyc = 16'($urandom_range(6));
      else if (pick < 8) w.cyc = 16'($urandom_range(3000));
      else if (pick == 8) w.cyc = '1;
    end
    return w;
  endfunction

  task automatic send_word(input timer_word_t w, input logic fixed, input timer_status_t want);
    timer_status_t predicted;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid       <= 1'b1;
    in_op          <= w.op;
    in_reg_index   <= w.idx;
    in_write_data  <= w.wdata;
    in_cycle_count <= w.cyc;
    do @(posedge clk); while (!in_ready);
    predicted = timer_status_after(w);
    status_due.push_back(fixed ? want : predicted);
  endtask

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    timer_status_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_read_data, out_irq_compare0, out_irq_compare1, out_active};
      if (status_due.size() == 0) begin
        if (failures < 10) $display("unexpected status word: rdata %h irq0 %b irq1 %b active %b",
                                    got.rdata, got.irq0, got.irq1, got.active);
        failures++;
      end else begin
        want = status_due.pop_front();
        if (got !== want) begin
          if (failures < 10)
            $display("status mismatch: want rdata %h irq %b%b active %b, got rdata %h irq %b%b active %b",
                     want.rdata, want.irq0, want.irq1, want.active,
                     got.rdata, got.irq0, got.irq1, got.active);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned   row, phase, n;
    timer_word_t   w;
    t_enable       = 1'b0;
    t_running      = 1'b0;
    t_restart_wait = 1'b0;
    t_count        = '0;
    t_cmp0         = COUNT_MASK;
    t_cmp1         = COUNT_MASK;
    t_acc          = 0;
    t_restart_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < N_DIRECTED; row++)
      send_word(DIRECTED_WORDS[row].word, DIRECTED_WORDS[row].fixed, DIRECTED_WORDS[row].want);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 82; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 82; end
        default: begin sender_idle_pct = 27; stall_pct = 27; end
      endcase
      repeat (PHASE_WORDS) send_word(pick_word(), 1'b0, '0);
    end

    // back-pressure: sink held off while words keep coming
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_left       = HOLD_CYCLES;
    repeat (30) send_word(pick_word(), 1'b0, '0);

    // run the count up to all ones
    send_word('{OP_WRITE, REG_CMP0, COUNT_MASK, 16'h0000}, 1'b0, '0);
    send_word('{OP_WRITE, REG_CMP1, 16'(16'hFF00 | $urandom_range(255)), 16'h0000}, 1'b0, '0);
    w                     = '{OP_WRITE, REG_CTRL, 16'h0000, 16'h0000};
    w.wdata[CTRL_ENABLE]  = 1'b1;
    w.wdata[CTRL_RESTART] = 1'b1;
    send_word(w, 1'b0, '0);
    n = 0;
    while (t_running || t_restart_wait) begin
      w.op    = (n % 32 == 31) ? OP_READ : OP_ADVANCE;
      w.idx   = REG_COUNT;
      w.wdata = 16'($urandom);
      w.cyc   = 16'(16'hFFFF - $urandom_range(15));
      send_word(w, 1'b0, '0);
      n++;
    end
    send_word('{OP_READ, REG_COUNT, 16'h0000, 16'h0000}, 1'b0, '0);
    send_word('{OP_ADVANCE, REG_COUNT, 16'h0000, 16'hFFFF}, 1'b0, '0);
    send_word('{OP_READ, REG_CTRL, 16'h0000, 16'h0000}, 1'b0, '0);

    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
